// File: sv/utsd_pkg.sv
`default_nettype none
package utsd_pkg;

  localparam int BYTE_W         = 8;
  localparam int LIMIT_W        = 11;
  localparam int STATUS_W       = 3;
  localparam int CP_W           = 21;
  localparam int CNT_W          = 3;
  localparam int POS_W          = 9;
  localparam int MAX_DESC_BYTES = 256;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET      = 11'd256;
  localparam logic [BYTE_W-1:0]   DESC_TYPE_STRING = 8'h03;
  localparam logic [POS_W-1:0]    POS_SAT          = 9'd511;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ODD      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LONE_LOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BROKEN   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DANGLING = 3'd5;

  typedef logic [STATUS_W-1:0] status_t;

  // One queued job: a code point with its (limit-clipped) byte count,
  // optionally followed by the end-of-descriptor status item.
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [CNT_W-1:0] cnt;
    logic             last;
    status_t          status;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/utsd_in_if.sv
`default_nettype none
interface utsd_in_if;
  import utsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

// File: sv/utsd_out_if.sv
`default_nettype none
interface utsd_out_if;
  import utsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_data;
  logic              out_last;
  status_t           status;
  modport source (output valid, output out_byte, output is_data, output out_last,
                  output status, input ready);
  modport sink (input valid, input out_byte, input is_data, input out_last,
                input status, output ready);
endinterface
`default_nettype wire

// File: sv/utsd_cfg_if.sv
`default_nettype none
interface utsd_cfg_if;
  import utsd_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] out_limit;
  modport source (output valid, output out_limit, input ready);
  modport sink (input valid, input out_limit, output ready);
endinterface
`default_nettype wire

// File: sv/utsd_front.sv
`default_nettype none
module utsd_front (
  input  logic          clk,
  input  logic          rst_n,
  utsd_in_if.sink       in_if,
  utsd_cfg_if.sink      cfg_if,
  input  logic          q_full,
  output logic          q_push,
  output utsd_pkg::cmd_t q_cmd
);
  import utsd_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]  decl_r, decl_nxt;
  logic [BYTE_W-1:0]  low_r, low_nxt;
  logic [9:0]         ph_r, ph_nxt;
  logic               hw_r, hw_nxt;
  logic [LIMIT_W-1:0] written_r, written_nxt;
  status_t            err_r, err_nxt;

  logic               accept;
  logic [15:0]        cu;
  logic               cu_low, cu_high;
  logic [CP_W-1:0]    cp;
  logic               emit;
  logic [CNT_W-1:0]   n_full;
  logic [CNT_W-1:0]   cnt;
  logic [LIMIT_W-1:0] room;
  logic [POS_W-1:0]   recv, r_eff;
  status_t            st;

  assign in_if.ready  = !q_full;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid && !q_full;

  assign cu      = {in_if.in_byte, low_r};
  assign cu_low  = (cu[15:10] == 6'b110111);
  assign cu_high = (cu[15:10] == 6'b110110);

  always_comb begin
    pos_nxt  = pos_r;
    decl_nxt = decl_r;
    low_nxt  = low_r;
    ph_nxt   = ph_r;
    hw_nxt   = hw_r;
    err_nxt  = err_r;
    cp       = '0;
    emit     = 1'b0;
    if (pos_r == '0) begin
      decl_nxt = in_if.in_byte;
    end else if (pos_r == POS_W'(1)) begin
      if (in_if.in_byte != DESC_TYPE_STRING && err_r == ST_OK) begin
        err_nxt = ST_SHORT;
      end
    end else if (pos_r < {1'b0, decl_r} && {1'b0, pos_r} < 10'(MAX_DESC_BYTES)) begin
      if (!pos_r[0]) begin
        low_nxt = in_if.in_byte;
      end else if (err_r == ST_OK && written_r < limit_r) begin
        if (cu_low) begin
          if (!hw_r) begin
            err_nxt = ST_LONE_LOW;
          end else begin
            cp     = 21'h10000 + CP_W'({ph_r, cu[9:0]});
            hw_nxt = 1'b0;
            ph_nxt = '0;
            emit   = 1'b1;
          end
        end else if (cu_high) begin
          if (hw_r) begin
            err_nxt = ST_BROKEN;
          end else begin
            ph_nxt = cu[9:0];
            hw_nxt = 1'b1;
          end
        end else begin
          if (hw_r) begin
            err_nxt = ST_BROKEN;
          end else begin
            cp   = CP_W'(cu);
            emit = 1'b1;
          end
        end
      end
    end
    pos_nxt = (pos_r == POS_SAT) ? pos_r : pos_r + POS_W'(1);
  end

  always_comb begin
    if (cp < 21'h80) begin
      n_full = CNT_W'(1);
    end else if (cp < 21'h800) begin
      n_full = CNT_W'(2);
    end else if (cp < 21'h10000) begin
      n_full = CNT_W'(3);
    end else begin
      n_full = CNT_W'(4);
    end
  end

  assign room        = limit_r - written_r;
  assign cnt         = !emit ? '0 : (room < LIMIT_W'(n_full)) ? room[CNT_W-1:0] : n_full;
  assign written_nxt = written_r + LIMIT_W'(cnt);

  always_comb begin
    recv  = pos_nxt;
    r_eff = ({1'b0, recv} > 10'(MAX_DESC_BYTES)) ? POS_W'(MAX_DESC_BYTES) : recv;
    if (r_eff > {1'b0, decl_nxt}) begin
      r_eff = {1'b0, decl_nxt};
    end
    if (recv < POS_W'(2) || err_nxt == ST_SHORT) begin
      st = ST_SHORT;
    end else if (r_eff[0]) begin
      st = ST_ODD;
    end else if (err_nxt != ST_OK) begin
      st = err_nxt;
    end else if (hw_nxt) begin
      st = ST_DANGLING;
    end else begin
      st = ST_OK;
    end
  end

  assign q_push       = accept && (cnt != '0 || in_if.in_last);
  assign q_cmd.cp     = cp;
  assign q_cmd.cnt    = cnt;
  assign q_cmd.last   = in_if.in_last;
  assign q_cmd.status = in_if.in_last ? st : ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RESET;
      pos_r     <= '0;
      decl_r    <= '0;
      low_r     <= '0;
      ph_r      <= '0;
      hw_r      <= 1'b0;
      written_r <= '0;
      err_r     <= ST_OK;
    end else begin
      if (cfg_if.valid) begin
        limit_r <= cfg_if.out_limit;
      end
      if (accept) begin
        if (in_if.in_last) begin
          pos_r     <= '0;
          decl_r    <= '0;
          low_r     <= '0;
          ph_r      <= '0;
          hw_r      <= 1'b0;
          written_r <= '0;
          err_r     <= ST_OK;
        end else begin
          pos_r     <= pos_nxt;
          decl_r    <= decl_nxt;
          low_r     <= low_nxt;
          ph_r      <= ph_nxt;
          hw_r      <= hw_nxt;
          written_r <= written_nxt;
          err_r     <= err_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/utsd_fifo.sv
`default_nettype none
module utsd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  utsd_pkg::cmd_t wr_data,
  input  logic           pop,
  output utsd_pkg::cmd_t rd_data,
  output logic           full,
  output logic           empty
);
  import utsd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/utsd_back.sv
`default_nettype none
module utsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  utsd_pkg::cmd_t q_cmd,
  output logic           q_pop,
  utsd_out_if.source     out_if
);
  import utsd_pkg::*;

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              is_data_r;
  logic              out_last_r;
  status_t           status_r;

  logic [BYTE_W-1:0] enc [4];
  logic              load;
  logic              data_step;

  always_comb begin
    enc[0] = '0;
    enc[1] = '0;
    enc[2] = '0;
    enc[3] = '0;
    if (q_cmd.cp < 21'h80) begin
      enc[0] = q_cmd.cp[7:0];
    end else if (q_cmd.cp < 21'h800) begin
      enc[0] = {3'b110, q_cmd.cp[10:6]};
      enc[1] = {2'b10, q_cmd.cp[5:0]};
    end else if (q_cmd.cp < 21'h10000) begin
      enc[0] = {4'b1110, q_cmd.cp[15:12]};
      enc[1] = {2'b10, q_cmd.cp[11:6]};
      enc[2] = {2'b10, q_cmd.cp[5:0]};
    end else begin
      enc[0] = {5'b11110, q_cmd.cp[20:18]};
      enc[1] = {2'b10, q_cmd.cp[17:12]};
      enc[2] = {2'b10, q_cmd.cp[11:6]};
      enc[3] = {2'b10, q_cmd.cp[5:0]};
    end
  end

  assign load      = !q_empty && (!out_valid_r || out_if.ready);
  assign data_step = (idx_r < q_cmd.cnt);

  always_comb begin
    q_pop   = 1'b0;
    idx_nxt = idx_r;
    if (load) begin
      if (data_step && !(idx_r == q_cmd.cnt - CNT_W'(1) && !q_cmd.last)) begin
        idx_nxt = idx_r + CNT_W'(1);
      end else begin
        q_pop   = 1'b1;
        idx_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (data_step) begin
        out_byte_r <= enc[idx_r[1:0]];
        is_data_r  <= 1'b1;
        out_last_r <= 1'b0;
        status_r   <= ST_OK;
      end else begin
        out_byte_r <= '0;
        is_data_r  <= 1'b0;
        out_last_r <= 1'b1;
        status_r   <= q_cmd.status;
      end
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.is_data  = is_data_r;
  assign out_if.out_last = out_last_r;
  assign out_if.status   = status_r;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r <= q_cmd.cnt)
    else $error("byte index past queued count");

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> !is_data_r && out_byte_r == '0)
    else $error("status transaction carries data");

  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> idx_r == '0)
    else $error("index not cleared after pop");
`endif

endmodule
`default_nettype wire

// File: sv/utf16le_string_desc_to_utf8.sv
`default_nettype none
// Channel   Dir  Payload                                  Handshake
// in_if     in   in_byte[7:0], in_last                    valid/ready
// out_if    out  out_byte[7:0], is_data, out_last, status valid/ready
// cfg_if    in   out_limit[10:0]                          valid/ready (always ready)
//
// Front takes one descriptor byte per cycle while the job queue has room.
// Back sends one transaction per cycle from a registered output stage while
// jobs are queued and out_if is ready. A code unit (two input bytes) yields
// up to three data bytes, so the output port sets the sustained pace.
// Reset (rst_n low, synchronous) clears the queue and all descriptor state.
module utf16le_string_desc_to_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  utsd_in_if.sink    in_if,
  utsd_out_if.source out_if,
  utsd_cfg_if.sink   cfg_if
);
  import utsd_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_wr, q_rd;

  utsd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_wr)
  );

  utsd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  utsd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (q_rd),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import utsd_pkg::*;

  localparam int QUIET_CYCLES = 20;
  localparam int TAIL_CYCLES  = 40;
  localparam int RX_HOLD      = 200;
  localparam int RANDOM_BYTES = 170;

  typedef enum logic [1:0] {OP_BYTE, OP_SYNC, OP_CFG} op_kind_t;

  typedef struct {
    op_kind_t           op;
    logic [BYTE_W-1:0]  data;
    logic               lst;
    logic [LIMIT_W-1:0] limit;
  } host_op_t;

  typedef struct {
    logic [BYTE_W-1:0] ob;
    logic              dat;
    logic              lst;
    status_t           st;
  } utf8_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  utsd_in_if  in_ch ();
  utsd_out_if out_ch ();
  utsd_cfg_if cfg_ch ();

  logic               drv_valid = 1'b0;
  logic [BYTE_W-1:0]  drv_byte = '0;
  logic               drv_last = 1'b0;
  logic               cfg_valid_r = 1'b0;
  logic [LIMIT_W-1:0] cfg_data_r = '0;
  logic               rx_ready = 1'b0;
  logic               in_fire = 1'b0;
  logic               cfg_fire = 1'b0;

  assign in_ch.valid      = drv_valid;
  assign in_ch.in_byte    = drv_byte;
  assign in_ch.in_last    = drv_last;
  assign cfg_ch.valid     = cfg_valid_r;
  assign cfg_ch.out_limit = cfg_data_r;
  assign out_ch.ready     = rx_ready;

  utf16le_string_desc_to_utf8 u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  host_op_t          host_ops_q[$];
  utf8_item_t        pending_utf8[$];
  logic [BYTE_W-1:0] desc_buf[$];

  int mismatches = 0;
  int in_count = 0;
  int rx_count = 0;
  int sent_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // decoder state mirror
  logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;
  logic [POS_W-1:0]   byte_pos = '0;
  logic [7:0]         decl_len = '0;
  logic [7:0]         low_hold = '0;
  logic [9:0]         pend_high = '0;
  logic               high_wait = 1'b0;
  logic [LIMIT_W-1:0] bytes_written = '0;
  status_t            latched_err = ST_OK;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic queue_result(input logic [7:0] b, input logic dat, input logic lst,
                              input status_t st);
    utf8_item_t item;
    item.ob  = b;
    item.dat = dat;
    item.lst = lst;
    item.st  = st;
    pending_utf8.push_back(item);
  endtask

  task automatic clear_desc_state();
    byte_pos      = '0;
    decl_len      = '0;
    low_hold      = '0;
    pend_high     = '0;
    high_wait     = 1'b0;
    bytes_written = '0;
    latched_err   = ST_OK;
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    logic [7:0] b[4];
    int n;
    if (cp < 21'h80) begin
      b[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      b[0] = 8'hC0 | {3'b000, cp[10:6]};
      b[1] = 8'h80 | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      b[0] = 8'hE0 | {4'h0, cp[15:12]};
      b[1] = 8'h80 | {2'b00, cp[11:6]};
      b[2] = 8'h80 | {2'b00, cp[5:0]};
      n = 3;
    end else begin
      b[0] = 8'hF0 | {5'b00000, cp[20:18]};
      b[1] = 8'h80 | {2'b00, cp[17:12]};
      b[2] = 8'h80 | {2'b00, cp[11:6]};
      b[3] = 8'h80 | {2'b00, cp[5:0]};
      n = 4;
    end
    for (int i = 0; i < n && bytes_written < model_limit; i++) begin
      queue_result(b[i], 1'b1, 1'b0, ST_OK);
      bytes_written++;
    end
  endtask

  task automatic take_code_unit(input logic [15:0] cu);
    if (latched_err != ST_OK || bytes_written >= model_limit) return;
    if (cu >= 16'hDC00 && cu < 16'hE000) begin
      if (!high_wait) begin
        latched_err = ST_LONE_LOW;
      end else begin
        high_wait = 1'b0;
        emit_code_point(21'h10000 + {1'b0, pend_high, cu[9:0]});
        pend_high = '0;
      end
    end else if (cu >= 16'hD800 && cu < 16'hDC00) begin
      if (high_wait) begin
        latched_err = ST_BROKEN;
      end else begin
        pend_high = cu[9:0];
        high_wait = 1'b1;
      end
    end else if (high_wait) begin
      latched_err = ST_BROKEN;
    end else begin
      emit_code_point({5'd0, cu});
    end
  endtask

  task automatic decode_desc_byte(input logic [7:0] b, input logic lst);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] eff;
    status_t st;
    p = byte_pos;
    if (p == 0) begin
      decl_len = b;
    end else if (p == 1) begin
      if (b != DESC_TYPE_STRING && latched_err == ST_OK) latched_err = ST_SHORT;
    end else if (p < {1'b0, decl_len} && p < MAX_DESC_BYTES) begin
      if (!p[0]) low_hold = b;
      else take_code_unit({b, low_hold});
    end
    if (byte_pos < POS_SAT) byte_pos++;
    if (lst) begin
      eff = (byte_pos > MAX_DESC_BYTES) ? POS_W'(MAX_DESC_BYTES) : byte_pos;
      if (byte_pos < 2 || latched_err == ST_SHORT) begin
        st = ST_SHORT;
      end else begin
        if (eff > {1'b0, decl_len}) eff = {1'b0, decl_len};
        if (eff[0]) st = ST_ODD;
        else if (latched_err != ST_OK) st = latched_err;
        else if (high_wait) st = ST_DANGLING;
        else st = ST_OK;
      end
      queue_result(8'h00, 1'b0, 1'b1, st);
      clear_desc_state();
    end
  endtask

  // monitor: results, config and input transactions
  always @(posedge clk) begin
    utf8_item_t want;
    in_fire  <= rst_n && in_ch.valid && in_ch.ready;
    cfg_fire <= rst_n && cfg_ch.valid && cfg_ch.ready;
    if (!rst_n) begin
      clear_desc_state();
      model_limit = LIMIT_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rx_count++;
        if (pending_utf8.size() == 0) begin
          report_mismatch("result with nothing expected", {8'h00, out_ch.out_byte}, 16'h0);
        end else begin
          want = pending_utf8.pop_front();
          if (out_ch.out_byte !== want.ob)
            report_mismatch("out_byte", 16'(out_ch.out_byte), 16'(want.ob));
          if (out_ch.is_data !== want.dat)
            report_mismatch("is_data", 16'(out_ch.is_data), 16'(want.dat));
          if (out_ch.out_last !== want.lst)
            report_mismatch("out_last", 16'(out_ch.out_last), 16'(want.lst));
          if (out_ch.status !== want.st)
            report_mismatch("status", 16'(out_ch.status), 16'(want.st));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) model_limit = cfg_ch.out_limit;
      if (in_ch.valid && in_ch.ready) begin
        in_count++;
        decode_desc_byte(in_ch.in_byte, in_ch.in_last);
      end
    end
  end

  // driver: byte stream and register writes
  always @(negedge clk) begin
    logic               nv;
    logic [BYTE_W-1:0]  nb;
    logic               nl;
    logic               cv;
    logic [LIMIT_W-1:0] cd;
    bit                 calm;
    nv = drv_valid;
    nb = drv_byte;
    nl = drv_last;
    cv = cfg_valid_r;
    cd = cfg_data_r;
    if (rst_n) begin
      if (pending_utf8.size() == 0 && !drv_valid) quiet_cycles++;
      else quiet_cycles = 0;
      if (drv_valid && in_fire) nv = 1'b0;
      if (cfg_valid_r && cfg_fire) cv = 1'b0;
      calm = sent_count >= 220 && sent_count < 320;
      if (!nv && !cv && host_ops_q.size() != 0) begin
        case (host_ops_q[0].op)
          OP_BYTE: begin
            if (calm || $urandom_range(0, 99) >= 23) begin
              nv = 1'b1;
              nb = host_ops_q[0].data;
              nl = host_ops_q[0].lst;
              void'(host_ops_q.pop_front());
              sent_count++;
            end
          end
          OP_SYNC: begin
            if (pending_utf8.size() == 0) void'(host_ops_q.pop_front());
          end
          OP_CFG: begin
            if (pending_utf8.size() == 0 && quiet_cycles >= QUIET_CYCLES) begin
              cv = 1'b1;
              cd = host_ops_q[0].limit;
              void'(host_ops_q.pop_front());
            end
          end
          default: void'(host_ops_q.pop_front());
        endcase
      end
    end
    drv_valid   <= nv;
    drv_byte    <= nb;
    drv_last    <= nl;
    cfg_valid_r <= cv;
    cfg_data_r  <= cd;
  end

  // result sink with one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        rx_ready <= 1'b0;
      end else if (!hold_done && in_count >= 150) begin
        hold_done = 1'b1;
        hold_left = RX_HOLD - 1;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= (rx_count >= 200 && rx_count < 300) || $urandom_range(0, 99) >= 23;
      end
    end
  end

  task automatic add_op(input op_kind_t op, input logic [7:0] b, input logic lst,
                        input logic [LIMIT_W-1:0] lim);
    host_op_t h;
    h.op    = op;
    h.data  = b;
    h.lst   = lst;
    h.limit = lim;
    host_ops_q.push_back(h);
  endtask

  task automatic add_cfg(input logic [LIMIT_W-1:0] lim);
    add_op(OP_CFG, 8'h00, 1'b0, lim);
  endtask

  task automatic flush_desc();
    for (int i = 0; i < desc_buf.size(); i++) begin
      if ($urandom_range(0, 199) == 0) add_op(OP_SYNC, 8'h00, 1'b0, '0);
      add_op(OP_BYTE, desc_buf[i], i == desc_buf.size() - 1, '0);
    end
    desc_buf.delete();
  endtask

  task automatic push_unit(input logic [15:0] cu);
    desc_buf.push_back(cu[7:0]);
    desc_buf.push_back(cu[15:8]);
  endtask

  // mostly well-formed descriptors, some broken on purpose; returns bytes that count
  task automatic gen_desc(output int used);
    int nunits;
    int cnt;
    int mode;
    int kind;
    int pos;
    int lim;
    logic [19:0] v;
    logic [15:0] cu;
    nunits = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 126) : $urandom_range(0, 12);
    mode = $urandom_range(0, 99);
    desc_buf.push_back(8'(2 + 2 * nunits));
    desc_buf.push_back(DESC_TYPE_STRING);
    cnt = 0;
    while (cnt < nunits) begin
      kind = $urandom_range(0, 99);
      if (kind < 15 && cnt + 1 < nunits) begin
        v = 20'($urandom_range(0, 20'hFFFFF));
        push_unit({6'b110110, v[19:10]});
        push_unit({6'b110111, v[9:0]});
        cnt += 2;
      end else begin
        if (kind < 50) begin
          cu = 16'($urandom_range(0, 16'h7F));
        end else if (kind < 70) begin
          cu = 16'($urandom_range(16'h80, 16'h7FF));
        end else if (kind < 95) begin
          cu = 16'($urandom_range(16'h800, 16'hFFFF));
          if (cu >= 16'hD800 && cu < 16'hE000) cu ^= 16'h2000;
        end else begin
          cu = 16'($urandom_range(0, 16'hFFFF));
        end
        push_unit(cu);
        cnt++;
      end
    end
    if (mode >= 65 && mode < 72) begin
      desc_buf[1] = 8'(3 + $urandom_range(1, 255));
    end else if (mode < 79 && mode >= 72) begin
      desc_buf[0] = 8'($urandom_range(0, 255));
    end else if (mode < 86 && mode >= 79 && desc_buf.size() > 1) begin
      repeat ($urandom_range(1, desc_buf.size() - 1)) void'(desc_buf.pop_back());
    end else if (mode < 92 && mode >= 86) begin
      repeat ($urandom_range(1, 6)) desc_buf.push_back(8'($urandom_range(0, 255)));
    end else if (mode >= 92 && nunits > 0) begin
      pos = $urandom_range(0, nunits - 1);
      cu = 16'($urandom_range(16'hD800, 16'hDFFF));
      desc_buf[2 + 2 * pos] = cu[7:0];
      desc_buf[3 + 2 * pos] = cu[15:8];
    end
    lim = (desc_buf[0] < 2) ? 2 : desc_buf[0];
    used = (desc_buf.size() < lim) ? desc_buf.size() : lim;
    flush_desc();
  endtask

  initial begin
    int budget;
    int used;
    int ndesc;

    // directed
    desc_buf = '{8'h01};
    flush_desc();
    desc_buf = '{8'hFF, 8'h00};
    flush_desc();
    desc_buf = '{8'h0C, 8'h03, 8'h41, 8'h00, 8'hE9, 8'h00, 8'hAC, 8'h20,
                 8'h3D, 8'hD8, 8'h00, 8'hDE};
    flush_desc();
    desc_buf = '{8'h03, 8'h03, 8'h41, 8'h00};
    flush_desc();
    desc_buf = '{8'h04, 8'h03, 8'h00, 8'hDC};
    flush_desc();
    desc_buf = '{8'h06, 8'h03, 8'h00, 8'hD8, 8'h41, 8'h00};
    flush_desc();
    desc_buf = '{8'h04, 8'h03, 8'hFF, 8'hDB};
    flush_desc();
    add_cfg(11'd1);
    desc_buf = '{8'h04, 8'h03, 8'hAC, 8'h20};
    flush_desc();

    // random
    budget = 0;
    ndesc = 0;
    while (budget < RANDOM_BYTES) begin
      if (ndesc % 6 == 0) begin
        case ((ndesc / 6) % 6)
          0: add_cfg(11'd1024);
          1: add_cfg(11'($urandom_range(2, 24)));
          2: add_cfg(LIMIT_RESET);
          3: add_cfg(11'd1);
          4: add_cfg(11'($urandom_range(1, 1024)));
          default: add_cfg(11'($urandom_range(3, 12)));
        endcase
      end
      gen_desc(used);
      budget += used;
      ndesc++;
    end

    // long descriptor with trailing bytes past the declared length
    add_cfg(11'd1024);
    desc_buf.push_back(8'hFE);
    desc_buf.push_back(DESC_TYPE_STRING);
    repeat (126) push_unit(16'($urandom_range(16'h20, 16'h7FF)));
    repeat (12) desc_buf.push_back(8'($urandom_range(0, 255)));
    flush_desc();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (host_ops_q.size() != 0 || drv_valid || cfg_valid_r || pending_utf8.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
